>>> rtl/core/dsfr_pkg.sv
package dsfr_pkg;

  localparam logic [7:0]  ByteDle = 8'h90;
  localparam logic [7:0]  ByteStx = 8'h02;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [1:0] StatusBusy = 2'd0;
  localparam logic [1:0] StatusGood = 2'd1;
  localparam logic [1:0] StatusBad  = 2'd2;

  typedef enum logic [6:0] {
    PhDle  = 7'b0000001,
    PhStx  = 7'b0000010,
    PhOpc  = 7'b0000100,
    PhLen  = 7'b0001000,
    PhData = 7'b0010000,
    PhCrc1 = 7'b0100000,
    PhCrc2 = 7'b1000000
  } phase_e;

  // eight msb-first crc steps with zero data shifted in; data bits of a byte
  // then just xor into the low byte, since the crc is linear
  function automatic logic [15:0] crc_shift8(input logic [15:0] crc);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/dle_stuffed_frame_receiver_crc16.sv
// a result passes through the input register, then decode and crc update
// into the result register
// throughput: one item per cycle; input stalls only when both registers are
// full and the result side holds off
// reset: asynchronous, active low; hunts for dle with crc, counters cleared
module dle_stuffed_frame_receiver_crc16 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic [8:0] payload_index_o,
  output logic [7:0] frame_opcode_o,
  output logic [7:0] frame_words_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  logic       fire;

  dsfr_pkg::phase_e phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  words_q, words_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  prev_q, prev_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic [1:0]  status_d;
  logic        pv_d;
  logic [7:0]  pb_d;
  logic [8:0]  pi_d;

  logic [7:0]  d;
  logic [8:0]  count_inc;
  logic [15:0] fin_crc;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign d          = in_byte_q;
  assign count_inc  = count_q + 9'd1;
  assign fin_crc    = dsfr_pkg::crc_shift8(crc_q);

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    opcode_d = opcode_q;
    words_d  = words_q;
    count_d  = count_q;
    prev_d   = prev_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    status_d = dsfr_pkg::StatusBusy;
    pv_d     = 1'b0;
    pb_d     = 8'h00;
    pi_d     = '0;

    if (esc_q && d == dsfr_pkg::ByteStx) begin
      phase_d = dsfr_pkg::PhOpc;
      esc_d   = 1'b0;
    end else if (phase_q == dsfr_pkg::PhDle && d == dsfr_pkg::ByteDle) begin
      phase_d = dsfr_pkg::PhStx;
    end else if (d == dsfr_pkg::ByteDle && !esc_q) begin
      esc_d = 1'b1;
    end else begin
      // doubled dle falls through as a data byte
      if (d == dsfr_pkg::ByteDle) esc_d = 1'b0;
      case (phase_q)
        dsfr_pkg::PhStx: begin
          phase_d = (d == dsfr_pkg::ByteStx) ? dsfr_pkg::PhOpc : dsfr_pkg::PhDle;
        end
        dsfr_pkg::PhOpc: begin
          opcode_d = d;
          phase_d  = dsfr_pkg::PhLen;
        end
        dsfr_pkg::PhLen: begin
          words_d = d;
          count_d = '0;
          // header word len<<8 | opcode from a zero crc
          crc_d   = dsfr_pkg::crc_shift8({8'h00, d}) ^ {8'h00, opcode_q};
          phase_d = (d == 8'h00) ? dsfr_pkg::PhCrc1 : dsfr_pkg::PhData;
        end
        dsfr_pkg::PhData: begin
          pv_d    = 1'b1;
          pb_d    = d;
          pi_d    = count_q;
          // word crc split in two byte halves: shift on the low byte,
          // fold in high and low bytes on the second
          if (count_q[0]) begin
            crc_d = dsfr_pkg::crc_shift8(crc_q ^ {8'h00, d}) ^ {8'h00, prev_q};
          end else begin
            crc_d = dsfr_pkg::crc_shift8(crc_q);
          end
          prev_d  = d;
          count_d = count_inc;
          if (count_inc == {words_q, 1'b0}) phase_d = dsfr_pkg::PhCrc1;
        end
        dsfr_pkg::PhCrc1: begin
          crc_lo_d = d;
          // first half of the appended zero word
          crc_d    = dsfr_pkg::crc_shift8(crc_q);
          phase_d  = dsfr_pkg::PhCrc2;
        end
        dsfr_pkg::PhCrc2: begin
          phase_d  = dsfr_pkg::PhDle;
          status_d = ({d, crc_lo_q} == fin_crc) ? dsfr_pkg::StatusGood
                                                : dsfr_pkg::StatusBad;
        end
        default: begin
          phase_d = dsfr_pkg::PhDle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= dsfr_pkg::PhDle;
      esc_q     <= 1'b0;
      opcode_q  <= 8'h00;
      words_q   <= 8'h00;
      count_q   <= '0;
      prev_q    <= 8'h00;
      crc_q     <= 16'h0000;
      crc_lo_q  <= 8'h00;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (fire) begin
        phase_q  <= phase_d;
        esc_q    <= esc_d;
        opcode_q <= opcode_d;
        words_q  <= words_d;
        count_q  <= count_d;
        prev_q   <= prev_d;
        crc_q    <= crc_d;
        crc_lo_q <= crc_lo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_byte_q <= rx_byte_i;
    if (fire) begin
      status_o        <= status_d;
      payload_valid_o <= pv_d;
      payload_byte_o  <= pb_d;
      payload_index_o <= pi_d;
      frame_opcode_o  <= opcode_d;
      frame_words_o   <= words_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // input side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // a frame verdict always sends the block back to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && status_d != dsfr_pkg::StatusBusy) |=> (phase_q == dsfr_pkg::PhDle))
    else $error("frame end did not return to hunt");

  // a payload byte never carries a frame verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (status_o == dsfr_pkg::StatusBusy))
    else $error("payload byte with a frame status");

  // payload index stays inside the longest payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (payload_index_o <= 9'd509))
    else $error("payload index out of range");

endmodule

>>> dv/testbench.sv
module testbench;

  typedef struct packed {
    logic [1:0] status;
    logic       pvalid;
    logic [7:0] pbyte;
    logic [8:0] pindex;
    logic [7:0] opcode;
    logic [7:0] words;
  } rx_result_t;

  localparam int FrameGood   = 0;
  localparam int FrameBadCrc = 1;
  localparam int FrameCut    = 2;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned ByteTarget  = 1600;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ReportLimit = 10;

  // decodes the byte stream on its own and keeps the results still owed
  class frame_rx_model;
    dsfr_pkg::phase_e ph;
    bit          esc;
    logic [7:0]  opc_q;
    logic [7:0]  words_q;
    logic [7:0]  prev_q;
    logic [7:0]  crc_lo_q;
    logic [8:0]  count_q;
    logic [15:0] crc_q;
    rx_result_t  expected_q[$];
    int unsigned mismatches;

    function new();
      ph = dsfr_pkg::PhDle;
      esc = 1'b0;
      opc_q = '0;
      words_q = '0;
      prev_q = '0;
      crc_lo_q = '0;
      count_q = '0;
      crc_q = '0;
      mismatches = 0;
    endfunction

    // msb first, one word of data shifted in behind the register
    static function logic [15:0] crc_word(logic [15:0] crc, logic [15:0] w);
      logic        carry;
      logic [15:0] c;
      c = crc;
      for (int i = 15; i >= 0; i--) begin
        carry = c[15];
        c = {c[14:0], w[i]};
        if (carry) c = c ^ dsfr_pkg::CrcPoly;
      end
      return c;
    endfunction

    function void note_byte(logic [7:0] d);
      rx_result_t r;
      r = '0;
      if (esc && d == dsfr_pkg::ByteStx) begin
        ph = dsfr_pkg::PhOpc;
        esc = 1'b0;
      end else if (ph == dsfr_pkg::PhDle && d == dsfr_pkg::ByteDle) begin
        ph = dsfr_pkg::PhStx;
      end else if (d == dsfr_pkg::ByteDle && !esc) begin
        esc = 1'b1;
      end else begin
        // doubled dle falls through as a data byte
        if (d == dsfr_pkg::ByteDle) esc = 1'b0;
        if (ph == dsfr_pkg::PhStx && d == dsfr_pkg::ByteStx) begin
          ph = dsfr_pkg::PhOpc;
        end else begin
          case (ph)
            dsfr_pkg::PhOpc: begin
              opc_q = d;
              ph = dsfr_pkg::PhLen;
            end
            dsfr_pkg::PhLen: begin
              words_q = d;
              count_q = '0;
              crc_q = crc_word(16'h0000, {d, opc_q});
              ph = (d == 8'h00) ? dsfr_pkg::PhCrc1 : dsfr_pkg::PhData;
            end
            dsfr_pkg::PhData: begin
              r.pvalid = 1'b1;
              r.pbyte = d;
              r.pindex = count_q;
              if (count_q[0]) crc_q = crc_word(crc_q, {d, prev_q});
              prev_q = d;
              count_q = count_q + 9'd1;
              if (count_q == {words_q, 1'b0}) ph = dsfr_pkg::PhCrc1;
            end
            dsfr_pkg::PhCrc1: begin
              crc_lo_q = d;
              ph = dsfr_pkg::PhCrc2;
            end
            dsfr_pkg::PhCrc2: begin
              ph = dsfr_pkg::PhDle;
              r.status = ({d, crc_lo_q} == crc_word(crc_q, 16'h0000)) ?
                         dsfr_pkg::StatusGood : dsfr_pkg::StatusBad;
            end
            default: ph = dsfr_pkg::PhDle;
          endcase
        end
      end
      r.opcode = opc_q;
      r.words = words_q;
      expected_q.push_back(r);
    endfunction

    function void check_result(rx_result_t act);
      rx_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result with nothing pending: status %0d byte %h", act.status, act.pbyte);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act !== exp_r) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $write("mismatch (exp/act): status %0d/%0d pvalid %0d/%0d byte %h/%h ",
                 exp_r.status, act.status, exp_r.pvalid, act.pvalid,
                 exp_r.pbyte, act.pbyte);
          $display("index %0d/%0d opcode %h/%h words %0d/%0d",
                   exp_r.pindex, act.pindex, exp_r.opcode, act.opcode,
                   exp_r.words, act.words);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] rx_status;
  logic       pay_valid;
  logic [7:0] pay_byte;
  logic [8:0] pay_index;
  logic [7:0] frame_opcode;
  logic [7:0] frame_words;

  frame_rx_model rx_model;
  int unsigned   burst_left;
  int unsigned   no_gap_left;
  int unsigned   bytes_sent;
  int unsigned   idle_cycles;
  bit            hold_request;

  dle_stuffed_frame_receiver_crc16 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (rx_status),
    .payload_valid_o(pay_valid),
    .payload_byte_o (pay_byte),
    .payload_index_o(pay_index),
    .frame_opcode_o (frame_opcode),
    .frame_words_o  (frame_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_byte(input logic [7:0] b);
    if (no_gap_left != 0) begin
      no_gap_left--;
    end else if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom);
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    rx_model.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    if (b == dsfr_pkg::ByteDle) send_byte(dsfr_pkg::ByteDle);
    send_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] opc, input logic [7:0] nwords, input int kind);
    logic [15:0] crc;
    logic [7:0]  b;
    logic [7:0]  lo_b;
    int unsigned stop_at;
    crc = frame_rx_model::crc_word(16'h0000, {nwords, opc});
    lo_b = '0;
    stop_at = (kind == FrameCut) ? $urandom_range(0, 2 * nwords) : 2 * nwords + 1;
    send_byte(dsfr_pkg::ByteDle);
    send_byte(dsfr_pkg::ByteStx);
    send_data(opc);
    send_data(nwords);
    for (int i = 0; i < 2 * nwords; i++) begin
      if (i == stop_at) return;
      case ($urandom_range(0, 15))
        0, 1:    b = dsfr_pkg::ByteDle;
        2:       b = dsfr_pkg::ByteStx;
        3:       b = 8'h00;
        4:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      if (i % 2 == 1) crc = frame_rx_model::crc_word(crc, {b, lo_b});
      else lo_b = b;
      send_data(b);
    end
    if (kind == FrameCut) return;
    crc = frame_rx_model::crc_word(crc, 16'h0000);
    if (kind == FrameBadCrc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_data(crc[7:0]);
    send_data(crc[15:8]);
  endtask

  // short bursts heavy in dle and stx to knock the decoder off track
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       send_byte(dsfr_pkg::ByteDle);
        1:       send_byte(dsfr_pkg::ByteStx);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // result side: ready pattern that changes mode now and then
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    bit          held;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 4);
        mode_left = $urandom_range(32, 400);
      end else begin
        mode_left--;
      end
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 4) != 0);
        3:       out_ready <= (mode_left % 5 != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      rx_model.check_result(rx_result_t'({rx_status, pay_valid, pay_byte, pay_index,
                                          frame_opcode, frame_words}));
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned nframes;
    int unsigned r;
    int          kind;
    logic [7:0]  nw;
    rx_model = new();
    rst_ni = 1'b0;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    burst_left = 0;
    no_gap_left = 0;
    bytes_sent = 0;
    hold_request = 1'b0;
    nframes = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // noise while hunting, stx with no dle, dle then a wrong byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dsfr_pkg::ByteStx);
    send_byte(dsfr_pkg::ByteDle);
    send_byte(8'h33);
    // zero length frame
    send_frame(8'hFF, 8'h00, FrameGood);
    // escape held over a data byte, then dle stx restarts mid-frame
    send_byte(dsfr_pkg::ByteDle);
    send_byte(dsfr_pkg::ByteStx);
    send_byte(8'h11);
    send_byte(8'h02);
    send_byte(8'hAA);
    send_byte(dsfr_pkg::ByteDle);
    send_byte(8'h55);
    send_byte(dsfr_pkg::ByteStx);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // stuffed opcode, one word, bad crc
    send_frame(dsfr_pkg::ByteDle, 8'h01, FrameBadCrc);

    // result side holds off while items keep coming back to back
    hold_request = 1'b1;
    no_gap_left = 120;
    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 9) < 7) begin
        if (nframes == 3) nw = 8'd255;
        else if (nframes == 9) nw = 8'($urandom_range(129, 254));
        else if ($urandom_range(0, 19) < 17) nw = 8'($urandom_range(0, 6));
        else nw = 8'($urandom_range(7, 40));
        r = $urandom_range(0, 19);
        kind = (r < 15) ? FrameGood : (r < 18) ? FrameBadCrc : FrameCut;
        send_frame(8'($urandom), nw, kind);
        nframes++;
      end else begin
        send_noise();
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (rx_model.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (rx_model.mismatches == 0 && rx_model.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/dsfr_pkg.sv
rtl/core/dle_stuffed_frame_receiver_crc16.sv
dv/testbench.sv
